/* sv/l2lf_pkg.sv */
// Package for the learning forwarder: sizes, payload structs, codes, flood mask.
// No dependencies.
package l2lf_pkg;
    localparam int TABLE_DEPTH = 64;
    localparam int NUM_PORTS   = 8;
    localparam int TIME_WIDTH  = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int PORT_W      = 3;
    localparam int MAC_W       = 48;
    localparam logic [TIME_WIDTH-1:0] DEFAULT_AGING = TIME_WIDTH'(10);
    localparam logic [MAC_W-1:0] MAC_BCAST = '1;

    localparam logic [1:0] ACT_UNICAST = 2'd0;
    localparam logic [1:0] ACT_FLOOD   = 2'd1;
    localparam logic [1:0] ACT_DISCARD = 2'd2;

    localparam logic [1:0] REG_AGING  = 2'd0;
    localparam logic [1:0] REG_LIMIT  = 2'd1;
    localparam logic [1:0] REG_PORTS  = 2'd2;

    typedef struct packed {
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic [2:0]  in_port;
        logic [31:0] now_tick;
    } t_in;

    typedef struct packed {
        logic [1:0] action;
        logic [2:0] out_port;
        logic [7:0] port_mask;
    } t_out;

    function automatic logic [7:0] flood_mask(input logic [3:0] n, input logic [2:0] p);
        logic [7:0] m;
        m = '0;
        for (int i = 0; i < NUM_PORTS; i++) begin
            if (4'(i) < n && 3'(i) != p) m[i] = 1'b1;
        end
        return m;
    endfunction
endpackage

/* sv/l2_learning_forwarder.sv */
// Learning forwarder top level: sequencer walking the MAC table one entry per cycle.
// Depends on l2lf_pkg.
//
//  channel | signals                                   | direction
//  cmd     | i_start, o_busy, i_item                   | in
//  result  | o_strobe, o_result                        | out (one cycle)
//  config  | i_cfg_valid, o_cfg_ready, i_cfg_index/data| in
//
// Each table scan (source lookup with valid count, aging sweep, oldest search,
// destination lookup) reads one entry a cycle from the single table memory; a hit
// ends a lookup early. The free slot comes from a priority search over the valid
// bits, and the result strobes in the last busy cycle.
// Reset clears the valid bits at once; the receiver cannot stall results.
module l2_learning_forwarder
    import l2lf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  t_in         i_item,
    output logic        o_strobe,
    output t_out        o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_SRC   = 8'b00000010,
        S_AGE   = 8'b00000100,
        S_OLD   = 8'b00001000,
        S_FREE  = 8'b00010000,
        S_DST   = 8'b00100000,
        S_FIN   = 8'b01000000,
        S_OUT   = 8'b10000000
    } t_state;

    t_state r_state, n_state;
    logic [31:0] r_aging;
    logic [6:0]  r_limit;
    logic [3:0]  r_ports;
    t_in         r_item;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [CNT_W-1:0] r_cnt;       // scan position, MSB set when done
    logic [CNT_W-1:0] r_nvalid;    // count of valid entries at scan
    logic        r_rd_ok;          // read data belongs to r_cnt-1
    logic [IDX_W-1:0] r_rd_idx;
    logic [IDX_W-1:0] r_best;
    logic        r_best_ok;
    logic [31:0] r_best_age;
    logic        r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic [2:0]  r_hit_port;
    logic        r_hit_aged;
    t_out        r_res;
    logic        r_strobe;

    logic [MAC_W-1:0]      mem_mac   [TABLE_DEPTH];
    logic [PORT_W-1:0]     mem_port  [TABLE_DEPTH];
    logic [TIME_WIDTH-1:0] mem_stamp [TABLE_DEPTH];
    logic [MAC_W-1:0]      r_q_mac;
    logic [PORT_W-1:0]     r_q_port;
    logic [TIME_WIDTH-1:0] r_q_stamp;
    logic        wr_en;
    logic [IDX_W-1:0] wr_idx;

    logic [31:0] aging_eff, age;
    logic [CNT_W-1:0] limit_eff;
    logic        aged, vld, done;

    assign aging_eff = (r_aging == '0) ? DEFAULT_AGING : r_aging;
    assign limit_eff = (r_limit == '0 || r_limit > 7'(TABLE_DEPTH)) ?
                       CNT_W'(TABLE_DEPTH) : CNT_W'(r_limit);
    assign age  = r_item.now_tick - r_q_stamp;
    assign aged = age >= aging_eff;
    assign vld  = r_rd_ok && r_valid[r_rd_idx];
    assign done = r_cnt[CNT_W-1];

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_result    = r_res;

    // table memory: one read port, one write port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_mac[wr_idx]   <= r_item.src_mac;
            mem_port[wr_idx]  <= r_item.in_port;
            mem_stamp[wr_idx] <= r_item.now_tick;
        end
        r_q_mac   <= mem_mac[r_cnt[IDX_W-1:0]];
        r_q_port  <= mem_port[r_cnt[IDX_W-1:0]];
        r_q_stamp <= mem_stamp[r_cnt[IDX_W-1:0]];
    end

    always_comb begin
        n_state = r_state;
        wr_en   = 1'b0;
        wr_idx  = r_hit_idx;
        case (r_state)
            S_IDLE: if (i_start) n_state = S_SRC;
            S_SRC: if (r_hit) begin
                wr_en = 1'b1; n_state = S_DST;
            end else if (done && !r_rd_ok) begin
                if (r_nvalid >= limit_eff) n_state = S_AGE;
                else n_state = S_FREE;
            end
            S_AGE: if (done && !r_rd_ok) begin
                if (r_nvalid >= limit_eff) n_state = S_OLD;
                else n_state = S_FREE;
            end
            S_OLD: if (done && !r_rd_ok) n_state = S_FREE;
            S_FREE: begin
                n_state = S_DST;
                wr_idx  = r_best;
                wr_en   = r_best_ok;
            end
            S_DST: if (r_hit || (done && !r_rd_ok)) n_state = S_FIN;
            S_FIN: n_state = S_OUT;
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_aging  <= DEFAULT_AGING;
            r_limit  <= '0;
            r_ports  <= 4'd8;
            r_valid  <= '0;
            r_strobe <= 1'b0;
            r_cnt    <= '0;
            r_rd_ok  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= 1'b0;
            r_rd_ok  <= !done && r_state != S_IDLE && r_state != S_FREE
                        && r_state != S_FIN && r_state != S_OUT && !r_hit;
            r_rd_idx <= r_cnt[IDX_W-1:0];
            if (!done && r_state != S_IDLE) r_cnt <= r_cnt + 1'b1;
            if (r_state != n_state) begin
                r_cnt   <= '0;
                r_rd_ok <= 1'b0;
                r_best_ok <= 1'b0;
                // keep the destination hit for the decision
                if (n_state != S_FIN) r_hit <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        case (i_cfg_index)
                            REG_AGING: r_aging <= i_cfg_data;
                            REG_LIMIT: r_limit <= i_cfg_data[6:0];
                            REG_PORTS: r_ports <= i_cfg_data[3:0];
                            default: ;
                        endcase
                    end
                    if (i_start) begin
                        r_item <= i_item;
                        r_cnt <= '0; r_rd_ok <= 1'b0; r_hit <= 1'b0;
                        r_nvalid <= '0; r_best_ok <= 1'b0;
                    end
                end
                S_SRC: begin
                    // hit refreshes through the write port at r_hit_idx
                    if (vld && !r_hit && r_q_mac == r_item.src_mac) begin
                        r_hit <= 1'b1; r_hit_idx <= r_rd_idx;
                    end
                    if (vld) r_nvalid <= r_nvalid + 1'b1;
                    if (n_state == S_AGE) r_nvalid <= '0;
                end
                S_AGE: begin
                    if (vld && aged) r_valid[r_rd_idx] <= 1'b0;
                    else if (vld) r_nvalid <= r_nvalid + 1'b1;
                end
                S_OLD: begin
                    if (vld && (!r_best_ok || age > r_best_age)) begin
                        r_best_ok <= 1'b1; r_best <= r_rd_idx; r_best_age <= age;
                    end
                    if (n_state == S_FREE && r_best_ok) r_valid[r_best] <= 1'b0;
                end
                default: ;
            endcase
            // free slot search: priority over valid bits (flip-flops)
            if (n_state == S_FREE) begin
                r_best_ok <= 1'b0;
                for (int i = TABLE_DEPTH-1; i >= 0; i--) begin
                    if (!r_valid[i] || (r_state == S_OLD && r_best_ok &&
                        r_best == IDX_W'(i))) begin
                        r_best_ok <= 1'b1; r_best <= IDX_W'(i);
                    end
                end
            end
            if (r_state == S_FREE && r_best_ok) r_valid[r_best] <= 1'b1;
            if (r_state == S_DST) begin
                if (vld && !r_hit && r_q_mac == r_item.dst_mac) begin
                    r_hit <= 1'b1; r_hit_idx <= r_rd_idx;
                    r_hit_port <= r_q_port; r_hit_aged <= aged;
                end
            end
            if (r_state == S_FIN) begin
                if (r_item.dst_mac == MAC_BCAST || !r_hit || r_hit_aged) begin
                    if (r_item.dst_mac != MAC_BCAST && r_hit) r_valid[r_hit_idx] <= 1'b0;
                    r_res.action    <= ACT_FLOOD;
                    r_res.out_port  <= '0;
                    r_res.port_mask <= flood_mask(r_ports, r_item.in_port);
                end else if (r_hit_port == r_item.in_port) begin
                    r_res.action <= ACT_DISCARD;
                    r_res.out_port <= '0; r_res.port_mask <= '0;
                end else begin
                    r_res.action <= ACT_UNICAST;
                    r_res.out_port <= r_hit_port;
                    r_res.port_mask <= 8'(1) << r_hit_port;
                end
                r_strobe <= 1'b1;
            end
        end
    end
endmodule

/* verif/tb_top.sv */
// Testbench for the learning forwarder: drives frame headers and register writes,
// predicts forwarding decisions with a behavioral MAC table and checks each result.
// Depends on l2lf_pkg and l2_learning_forwarder.
`timescale 1ns / 100ps

module tb_top;
    import l2lf_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    t_in         i_item;
    logic        o_strobe;
    t_out        o_result;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    l2_learning_forwarder DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // predictor state
    logic [31:0] aging_reg;
    logic [6:0]  limit_reg;
    logic [3:0]  ports_reg;
    logic        tbl_valid [TABLE_DEPTH];
    logic [47:0] tbl_mac   [TABLE_DEPTH];
    logic [2:0]  tbl_port  [TABLE_DEPTH];
    logic [31:0] tbl_stamp [TABLE_DEPTH];

    t_out        expected_q[$];
    int          n_errors;
    int          idle_pct;
    logic [31:0] tick;
    logic [47:0] mac_pool [16];

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        n_errors++;
    endtask

    function automatic bit entry_aged(input int i, input logic [31:0] now);
        logic [31:0] a;
        a = (aging_reg == 0) ? DEFAULT_AGING : aging_reg;
        return (now - tbl_stamp[i]) >= a;
    endfunction

    function automatic int lookup_mac(input logic [47:0] mac);
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (tbl_valid[i] && tbl_mac[i] == mac) return i;
        return -1;
    endfunction

    function automatic int valid_count();
        int n;
        n = 0;
        for (int i = 0; i < TABLE_DEPTH; i++) n += tbl_valid[i];
        return n;
    endfunction

    function automatic logic [7:0] ports_flood(input logic [2:0] p);
        logic [7:0] m;
        m = '0;
        for (int i = 0; i < NUM_PORTS; i++)
            if (i < ports_reg && i != p) m[i] = 1'b1;
        return m;
    endfunction

    function automatic t_out forward_decision(input t_in f);
        t_out r;
        int hit, lim, oldest, slot;
        logic [31:0] best, age;
        hit = lookup_mac(f.src_mac);
        if (hit >= 0) begin
            tbl_port[hit] = f.in_port;
            tbl_stamp[hit] = f.now_tick;
        end else begin
            lim = limit_reg;
            if (lim == 0 || lim > TABLE_DEPTH) lim = TABLE_DEPTH;
            if (valid_count() >= lim) begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                    if (tbl_valid[i] && entry_aged(i, f.now_tick)) tbl_valid[i] = 1'b0;
                if (valid_count() >= lim) begin
                    oldest = -1;
                    best = 0;
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        age = f.now_tick - tbl_stamp[i];
                        if (tbl_valid[i] && (oldest < 0 || age > best)) begin
                            oldest = i;
                            best = age;
                        end
                    end
                    if (oldest >= 0) tbl_valid[oldest] = 1'b0;
                end
            end
            slot = -1;
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (!tbl_valid[i] && slot < 0) slot = i;
            if (slot >= 0) begin
                tbl_valid[slot] = 1'b1;
                tbl_mac[slot] = f.src_mac;
                tbl_port[slot] = f.in_port;
                tbl_stamp[slot] = f.now_tick;
            end
        end
        r = '0;
        if (f.dst_mac == MAC_BCAST) begin
            r.action = ACT_FLOOD;
            r.port_mask = ports_flood(f.in_port);
        end else begin
            hit = lookup_mac(f.dst_mac);
            if (hit >= 0 && entry_aged(hit, f.now_tick)) begin
                tbl_valid[hit] = 1'b0;
                hit = -1;
            end
            if (hit < 0) begin
                r.action = ACT_FLOOD;
                r.port_mask = ports_flood(f.in_port);
            end else if (tbl_port[hit] == f.in_port) begin
                r.action = ACT_DISCARD;
            end else begin
                r.action = ACT_UNICAST;
                r.out_port = tbl_port[hit];
                r.port_mask = 8'(1) << tbl_port[hit];
            end
        end
        return r;
    endfunction

    // start stays high after the accept edge until the next beat or an idle stretch
    task automatic send_frame(input t_in f);
        if ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < idle_pct) @(posedge i_clk);
        end
        i_item <= f;
        i_start <= 1'b1;
        @(negedge i_clk);
        while (o_busy) @(negedge i_clk);
        @(posedge i_clk);
        expected_q.push_back(forward_decision(f));
    endtask

    task automatic drain();
        i_start <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_AGING: aging_reg = val;
            REG_LIMIT: limit_reg = val[6:0];
            REG_PORTS: ports_reg = val[3:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic t_in make_frame(input logic [47:0] s, input logic [47:0] d,
                                       input logic [2:0] p, input logic [31:0] t);
        t_in f;
        f.src_mac = s;
        f.dst_mac = d;
        f.in_port = p;
        f.now_tick = t;
        return f;
    endfunction

    // check each result beat against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (expected_q.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                t_out e;
                e = expected_q.pop_front();
                if (o_result.action !== e.action)
                    report_mismatch($sformatf("action %0d exp %0d",
                                              o_result.action, e.action));
                if (o_result.out_port !== e.out_port)
                    report_mismatch($sformatf("out_port %0d exp %0d",
                                              o_result.out_port, e.out_port));
                if (o_result.port_mask !== e.port_mask)
                    report_mismatch($sformatf("port_mask %h exp %h",
                                              o_result.port_mask, e.port_mask));
            end
        end
    end

    task automatic test_directed();
        idle_pct = 0;
        send_frame(make_frame(48'h0, 48'hFFFF_FFFF_FFFF, 3'd0, 32'd0));
        send_frame(make_frame(48'hFFFF_FFFF_FFFE, 48'h0, 3'd7, 32'd1));
        send_frame(make_frame(48'h1234, 48'h0, 3'd0, 32'd2));
        send_frame(make_frame(48'h0, 48'hFFFF_FFFF_FFFE, 3'd0, 32'd3));
        send_frame(make_frame(48'h5, 48'h1234, 3'd3, 32'd9));
        send_frame(make_frame(48'h6, 48'h1234, 3'd3, 32'd20));
        send_frame(make_frame(48'h1234, 48'hFFFF_FFFF_FFFF, 3'd3, 32'hFFFF_FFFF));
        send_frame(make_frame(48'h7, 48'h1234, 3'd4, 32'd4));
        drain();
        write_reg(REG_AGING, 32'd0);
        write_reg(REG_PORTS, 32'd0);
        write_reg(REG_LIMIT, 32'd2);
        send_frame(make_frame(48'hA, 48'hFFFF_FFFF_FFFF, 3'd1, 32'd100));
        send_frame(make_frame(48'hB, 48'hA, 3'd2, 32'd101));
        send_frame(make_frame(48'hC, 48'hA, 3'd2, 32'd102));
        send_frame(make_frame(48'hD, 48'hB, 3'd2, 32'd200));
        drain();
        write_reg(REG_PORTS, 32'd15);
        write_reg(REG_LIMIT, 32'd127);
        write_reg(REG_AGING, 32'hFFFF_FFFF);
        send_frame(make_frame(48'hE, 48'hD, 3'd5, 32'd300));
        send_frame(make_frame(48'hF, 48'hE, 3'd6, 32'd301));
        drain();
        write_reg(REG_LIMIT, 32'd1);
        write_reg(REG_PORTS, 32'd1);
        send_frame(make_frame(48'h10, 48'hF, 3'd0, 32'd302));
        send_frame(make_frame(48'h11, 48'h10, 3'd1, 32'd303));
        drain();
    endtask

    task automatic test_random(input int n_frames, input int pct, input int pool_n);
        t_in f;
        idle_pct = pct;
        for (int k = 0; k < n_frames; k++) begin
            tick = tick + $urandom_range(3);
            if ($urandom_range(19) == 0) tick = tick + $urandom_range(40);
            f.src_mac = ($urandom_range(9) == 0) ? 48'({$urandom, $urandom})
                                                 : mac_pool[$urandom_range(pool_n - 1)];
            case ($urandom_range(9))
                0: f.dst_mac = MAC_BCAST;
                1: f.dst_mac = 48'({$urandom, $urandom});
                default: f.dst_mac = mac_pool[$urandom_range(pool_n - 1)];
            endcase
            f.in_port = 3'($urandom_range(7));
            f.now_tick = tick;
            send_frame(f);
        end
        drain();
    endtask

    task automatic test_settings();
        write_reg(REG_AGING, 32'd30);
        write_reg(REG_LIMIT, 32'd6);
        write_reg(REG_PORTS, 32'd8);
        test_random(350, 0, 10);
        write_reg(REG_AGING, 32'd1);
        write_reg(REG_LIMIT, 32'd0);
        write_reg(REG_PORTS, 32'd5);
        test_random(300, 79, 16);
        write_reg(REG_AGING, 32'd200);
        write_reg(REG_LIMIT, 32'd64);
        write_reg(REG_PORTS, 32'd8);
        test_random(450, 32, 16);
        write_reg(REG_AGING, 32'd15);
        write_reg(REG_LIMIT, 32'd3);
        write_reg(REG_PORTS, 32'd3);
        test_random(380, 0, 8);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_AGING;
        i_cfg_data = '0;
        n_errors = 0;
        idle_pct = 0;
        tick = 32'd400;
        aging_reg = DEFAULT_AGING;
        limit_reg = '0;
        ports_reg = 4'd8;
        foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
        foreach (mac_pool[i]) mac_pool[i] = 48'({$urandom, $urandom});
        mac_pool[0] = 48'h0;
        mac_pool[1] = 48'hFFFF_FFFF_FFFE;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_settings();
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

/* filelist.f */
sv/l2lf_pkg.sv
sv/l2_learning_forwarder.sv
verif/tb_top.sv
